[rtl/pcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// shared types, constants and the per-pixel power factor tables
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int VAL_W     = 19;                    // operand width
    localparam int S2        = 2 * FRACTION_BITS;     // product fraction bits
    localparam int NINT      = VAL_W - 1 - FRACTION_BITS; // exponent integer bits
    localparam int NPOW      = NINT + FRACTION_BITS;  // power multiply steps
    localparam int DIV_STEPS = 8;                     // quotient bits below 256
    localparam int MOD_STEPS = 8 + FRACTION_BITS;     // bits of x << FRACTION_BITS
    localparam int NSTEP     = (NPOW > MOD_STEPS) ? NPOW : MOD_STEPS;
    localparam int P_W       = 2 * VAL_W;             // signed product width
    localparam int PU_W      = P_W - 1;               // positive product width
    localparam int DN_W      = 8 + S2;                // divide numerator width
    localparam int DC_W      = PU_W + DIV_STEPS;      // divide compare width
    localparam int MN_W      = 8 + FRACTION_BITS;     // modulo numerator width
    localparam int MC_W      = VAL_W + MOD_STEPS - 1; // modulo compare width

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4,
        OP_POW = 3'd5,
        OP_RS6 = 3'd6,
        OP_RS7 = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        MODE_GRAY0 = 3'd0,
        MODE_GRAY1 = 3'd1,
        MODE_GRAY2 = 3'd2,
        MODE_RED   = 3'd3,
        MODE_GREEN = 3'd4,
        MODE_BLUE  = 3'd5,
        MODE_RS6   = 3'd6,
        MODE_RS7   = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        REG_OPERATION = 2'd0,
        REG_VALUE_ONE = 2'd1,
        REG_VALUE_TWO = 2'd2,
        REG_CHAN_MODE = 2'd3
    } reg_idx_t;

    typedef struct packed {
        op_t                      op;
        logic signed [VAL_W-1:0]  v1;
        logic signed [VAL_W-1:0]  v2;
        mode_t                    mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0]              red;
        logic [7:0]              green;
        logic [7:0]              blue;
        logic [7:0]              alpha;
    } pix_t;

    typedef struct packed {
        pix_t                    pix;
        logic [7:0]              x;
        logic signed [P_W-1:0]   p;
        logic [7:0]              simple;
        logic                    dsat;
        logic [DN_W-1:0]         drem;
        logic [DIV_STEPS-1:0]    dquo;
        logic [MN_W-1:0]         mrem;
        logic                    acc_one;
        logic [31:0]             acc;
    } st_t;

    typedef logic [NPOW-1:0][255:0][31:0] ftab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_v;
        rem   = n;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // factor per step and pixel value: squares of the base, then square roots
    function automatic ftab_t build_ftab();
        ftab_t       t;
        logic [63:0] b;
        logic [63:0] r;
        t = '0;
        for (int x = 0; x < 256; x++) begin
            b = (64'(x) << 32) / 64'd255;
            r = b;
            for (int j = 0; j < NINT; j++) begin
                t[j][x] = b[31:0];
                b = 64'((b[31:0] * 64'(b[31:0])) >> 32);
            end
            for (int k = 0; k < FRACTION_BITS; k++) begin
                r = isqrt64({r[31:0], 32'd0});
                t[NINT+k][x] = r[31:0];
            end
        end
        return t;
    endfunction

    localparam ftab_t FTAB = build_ftab();

    // clamp to 0..255 after dropping the product fraction bits
    function automatic logic [7:0] clamp_fix(input logic signed [P_W+8:0] v);
        logic [7:0] q;
        if (v <= 0) begin
            q = 8'd0;
        end else if (v[P_W+8:S2] > 255) begin
            q = 8'd255;
        end else begin
            q = v[S2+7:S2];
        end
        return q;
    endfunction

endpackage

[rtl/pixel_channel_calculator_core.sv]
`timescale 1ns / 1ps
// path: input beat through the front stages, the step chain and the back output register
// throughput: one pixel per cycle while the pipe advances, every stage is a plain register with a valid bit
// the whole pipe advances when the output register is empty or being drained
// reset (aresetn low, synchronous) clears all valid bits and loads
// operation add, value_one 1.0, value_two 1.0, channel mode gray
// ----------------------------------------------------------------------------
// pixel_channel_calculator_core
// per-pixel arithmetic on one color channel, clamped to 0..255
// ----------------------------------------------------------------------------
module pixel_channel_calculator_core import pcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
    // pixel output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
    // register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [VAL_W-1:0] cfg_data
);

    // configuration registers
    cfg_t cfg_reg;

    // pipe enable: output register free or its beat taken this cycle
    logic en;

    pix_t in_pix;
    pix_t out_pix;

    logic front_valid;
    st_t  front_st;

    // step chain: element i feeds step i
    logic [NSTEP:0] chain_valid;
    st_t            chain_st [0:NSTEP];

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // red in the lowest byte
    assign in_pix.red   = s_tdata[7:0];
    assign in_pix.green = s_tdata[15:8];
    assign in_pix.blue  = s_tdata[23:16];
    assign in_pix.alpha = s_tdata[31:24];

    // register writes; issue them only while the pipe is empty (the block does not enforce this)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.op   <= OP_ADD;
            cfg_reg.v1   <= VAL_W'(1 << FRACTION_BITS);
            cfg_reg.v2   <= VAL_W'(1 << FRACTION_BITS);
            cfg_reg.mode <= MODE_GRAY0;
        end else if (cfg_valid) begin
            unique case (reg_idx_t'(cfg_index))
                REG_OPERATION: cfg_reg.op   <= op_t'(cfg_data[2:0]);
                REG_VALUE_ONE: cfg_reg.v1   <= cfg_data;
                REG_VALUE_TWO: cfg_reg.v2   <= cfg_data;
                REG_CHAN_MODE: cfg_reg.mode <= mode_t'(cfg_data[2:0]);
                default: ;
            endcase
        end
    end

    // two stages: channel pick with operand product, then add/sub/multiply
    pcc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_pix    (in_pix),
        .out_valid (front_valid),
        .out_st    (front_st)
    );

    assign chain_valid[0] = front_valid;
    assign chain_st[0]    = front_st;

    // at most one power factor, one divide bit and one modulo bit per stage
    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        pcc_step #(
            .IDX (i)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .cfg       (cfg_reg),
            .in_valid  (chain_valid[i]),
            .in_st     (chain_st[i]),
            .out_valid (chain_valid[i+1]),
            .out_st    (chain_st[i+1])
        );
    end

    // result select and channel write-back into the output register
    pcc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (chain_valid[NSTEP]),
        .in_st     (chain_st[NSTEP]),
        .out_valid (m_tvalid),
        .out_pix   (out_pix)
    );

    assign m_tdata = {out_pix.alpha, out_pix.blue, out_pix.green, out_pix.red};

endmodule

[rtl/pcc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_front
// channel pick, operand product and the direct add, subtract and multiply
// ----------------------------------------------------------------------------
module pcc_front import pcc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cfg_t  cfg,
    input  logic  in_valid,
    input  pix_t  in_pix,
    output logic  out_valid,
    output st_t   out_st
);

    logic               a_valid_reg;
    pix_t               a_pix_reg;
    logic [7:0]         a_x_reg;
    logic signed [P_W-1:0] a_p_reg;
    logic [7:0]         x_next;
    logic signed [P_W-1:0] p_next;

    logic               b_valid_reg;
    st_t                b_st_reg;
    st_t                b_st_next;

    logic signed [P_W+8:0] xs;
    logic signed [P_W+8:0] pe;
    logic signed [P_W+8:0] mulv;
    logic [DC_W-1:0]    pu_sh;

    always_comb begin
        case (cfg.mode)
            MODE_GREEN: x_next = in_pix.green;
            MODE_BLUE:  x_next = in_pix.blue;
            default:    x_next = in_pix.red;
        endcase
        p_next = P_W'(cfg.v1) * P_W'(cfg.v2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_pix_reg <= in_pix;
            a_x_reg   <= x_next;
            a_p_reg   <= p_next;
            b_st_reg  <= b_st_next;
        end
    end

    always_comb begin
        xs    = (P_W+9)'({a_x_reg, S2'(0)});
        pe    = (P_W+9)'(a_p_reg);
        mulv  = $signed({1'b0, a_x_reg}) * a_p_reg;
        pu_sh = {a_p_reg[PU_W-1:0], DIV_STEPS'(0)};

        b_st_next        = '0;
        b_st_next.pix    = a_pix_reg;
        b_st_next.x      = a_x_reg;
        b_st_next.p      = a_p_reg;
        case (cfg.op)
            OP_ADD:  b_st_next.simple = clamp_fix(xs + pe);
            OP_SUB:  b_st_next.simple = clamp_fix(xs - pe);
            default: b_st_next.simple = clamp_fix(mulv);
        endcase
        b_st_next.drem    = {a_x_reg, S2'(0)};
        b_st_next.dsat    = DC_W'({a_x_reg, S2'(0)}) >= pu_sh;
        b_st_next.dquo    = '0;
        b_st_next.mrem    = {a_x_reg, FRACTION_BITS'(0)};
        b_st_next.acc_one = 1'b1;
        b_st_next.acc     = '0;
    end

    assign out_valid = b_valid_reg;
    assign out_st    = b_st_reg;

endmodule

[rtl/pcc_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_step
// one pipeline step: power factor multiply, divide bit and modulo bit
// ----------------------------------------------------------------------------
module pcc_step import pcc_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cfg_t  cfg,
    input  logic  in_valid,
    input  st_t   in_st,
    output logic  out_valid,
    output st_t   out_st
);

    // bit positions kept in range for steps past the end of a unit
    localparam int FIDX = (IDX < NPOW) ? IDX : 0;
    localparam int EBIT = (IDX >= NPOW) ? 0 :
                          (IDX < NINT) ? FRACTION_BITS + IDX
                                       : FRACTION_BITS - 1 - (IDX - NINT);
    localparam int DBIT = (IDX < DIV_STEPS) ? DIV_STEPS - 1 - IDX : 0;
    localparam int MSH  = (IDX < MOD_STEPS) ? MOD_STEPS - 1 - IDX : 0;

    logic        valid_reg;
    st_t         st_reg;
    st_t         st_next;

    logic        ebit;
    logic [31:0] fac;
    logic [63:0] prod;
    logic [DC_W-1:0] dd;
    logic [MC_W-1:0] md;
    logic [VAL_W-1:0] mabs;

    always_comb begin
        st_next = in_st;
        ebit    = 1'b0;
        fac     = '0;
        prod    = '0;
        dd      = '0;
        md      = '0;
        mabs    = cfg.v2[VAL_W-1] ? VAL_W'(-cfg.v2) : VAL_W'(cfg.v2);

        if (IDX < NPOW) begin
            ebit = cfg.v2[EBIT];
            fac  = FTAB[FIDX][in_st.x];
            prod = 64'(in_st.acc) * 64'(fac);
            if (ebit) begin
                st_next.acc_one = 1'b0;
                st_next.acc     = in_st.acc_one ? fac : prod[63:32];
            end
        end

        if (IDX < DIV_STEPS) begin
            dd = DC_W'(in_st.p[PU_W-1:0]) << DBIT;
            if (DC_W'(in_st.drem) >= dd) begin
                st_next.drem = DN_W'(DC_W'(in_st.drem) - dd);
                st_next.dquo[DBIT] = 1'b1;
            end
        end

        if (IDX < MOD_STEPS) begin
            md = MC_W'(mabs) << MSH;
            if (MC_W'(in_st.mrem) >= md) begin
                st_next.mrem = MN_W'(MC_W'(in_st.mrem) - md);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_st    = st_reg;

endmodule

[rtl/pcc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_back
// result pick with special cases, channel write-back and output register
// ----------------------------------------------------------------------------
module pcc_back import pcc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  cfg_t  cfg,
    input  logic  in_valid,
    input  st_t   in_st,
    output logic  out_valid,
    output pix_t  out_pix
);

    logic        valid_reg;
    pix_t        pix_reg;
    pix_t        pix_next;
    logic [7:0]  res;
    logic [39:0] pw;

    always_comb begin
        pw = 40'(in_st.acc) * 40'd255;
        case (cfg.op)
            OP_ADD, OP_SUB, OP_MUL: res = in_st.simple;
            OP_DIV: begin
                if (cfg.v2 == 0) begin
                    res = 8'd0;
                end else if (cfg.v1 == 0) begin
                    res = (in_st.x != 0 && !cfg.v2[VAL_W-1]) ? 8'd255 : 8'd0;
                end else if (in_st.p < 0) begin
                    res = 8'd0;
                end else if (in_st.dsat) begin
                    res = 8'd255;
                end else begin
                    res = in_st.dquo;
                end
            end
            OP_MOD: begin
                res = (cfg.v2 == 0) ? 8'd0 : in_st.mrem[MN_W-1:FRACTION_BITS];
            end
            OP_POW: begin
                if (in_st.x == 8'd255 || cfg.v2 == 0 || cfg.v2[VAL_W-1]) begin
                    res = 8'd255;
                end else if (in_st.x == 8'd0) begin
                    res = 8'd0;
                end else if (in_st.acc_one) begin
                    res = 8'd255;
                end else begin
                    res = pw[39:32];
                end
            end
            default: res = 8'd0;
        endcase

        pix_next = in_st.pix;
        case (cfg.mode)
            MODE_GRAY0, MODE_GRAY1, MODE_GRAY2: begin
                pix_next.red   = res;
                pix_next.green = res;
                pix_next.blue  = res;
                pix_next.alpha = 8'd255;
            end
            MODE_RED:   pix_next.red   = res;
            MODE_GREEN: pix_next.green = res;
            MODE_BLUE:  pix_next.blue  = res;
            default:    pix_next = in_st.pix;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule
